@@ hw/rtl/mprb_pkg.sv @@
package mprb_pkg;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    CFG_ACCEL_STEP    = 2'd0,
    CFG_BRAKE_FACTOR  = 2'd1,
    CFG_STEP_INTERVAL = 2'd2,
    CFG_PWM_SCALE     = 2'd3
  } cfg_reg_e;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [14:0] ACCEL_STEP_RST    = 15'd1638;
  localparam logic [15:0] BRAKE_FACTOR_RST  = 16'd58982;
  localparam logic [15:0] STEP_INTERVAL_RST = 16'd10;
  localparam logic [15:0] PWM_SCALE_RST     = 16'd12800;

  // |power| below this (0.1 in Q1.15) brakes straight to zero
  localparam logic [15:0] ZERO_BRAKE_LIMIT = 16'd3277;

  // PWM bases in Q8.8
  localparam logic signed [18:0] PWM_BASE_NEG  = 19'sd23040;  // 90
  localparam logic signed [18:0] PWM_BASE_POS  = 19'sd25600;  // 100
  localparam logic        [15:0] PWM_BASE_ZERO = 16'd23808;   // 93

  typedef struct packed {
    logic [14:0] accel_step;
    logic [15:0] brake_factor;
    logic [15:0] step_interval;
    logic [15:0] pwm_scale;
  } cfg_t;

  // One entry of the per-motor state memory
  typedef struct packed {
    logic signed [15:0] power;
    logic        [31:0] stamp;
  } state_t;

  typedef struct packed {
    logic               wr;      // store next into the state memory
    state_t             next;
    logic signed [15:0] result;  // power handed downstream
  } ramp_t;

endpackage

@@ hw/rtl/motor_power_ramp_with_brake.sv @@
// Per-motor power slew limiter with braking and a Q8.8 PWM mapper. Each item
// names a motor, a requested Q1.15 power and the millisecond time; the block
// returns one item with the power to apply and its PWM command. One item is
// taken every clock cycle while in_stall_o is low: the rate is set by the
// read-modify-write of the per-motor state memory (power and last step time),
// which forwards its last write so that items for the same motor can follow
// each other directly. The brake multiply sits in the update stage and the
// PWM multiply gets the stage after it. After reset every motor reads as
// zero power at time zero; no clearing pass is needed. Configuration
// registers: 0 accel_step, 1 brake_factor, 2 step_interval_ms, 3 pwm_scale;
// the user must see that they are written only while the block is idle, as
// the block itself does not enforce it.
module motor_power_ramp_with_brake
  import mprb_pkg::*;
#(
  parameter int unsigned NUM_MOTORS = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [15:0]    requested_power_i,
  input  logic                  motor_index_i,
  input  logic [31:0]           now_ms_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [15:0]    ramped_power_o,
  output logic [15:0]           pwm_value_o
);

  localparam int unsigned IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

  cfg_t cfg_q;

  // pipeline: s1 = state update, s2 = PWM multiply, out = output register
  logic s1_v_q, s2_v_q, out_v_q;
  logic out_ready, s2_ready, s1_ready;
  logic accept, ld_mul, ld_out, mem_we;

  logic signed [15:0] req_q;
  logic        [31:0] now_q;
  logic [IDX_W-1:0]   idx_q;
  logic [IDX_W-1:0]   in_idx;

  // last write to the state memory, for a same-motor item right behind it
  logic             fwd_v_q;
  logic [IDX_W-1:0] fwd_idx_q;
  state_t           fwd_data_q;

  state_t mem_rdata;
  state_t cur;
  ramp_t  ramp;

  logic signed [15:0] ramp_power_int;
  logic        [15:0] pwm_int;

  // motor index wraps modulo NUM_MOTORS; with one motor it is always 0
  assign in_idx = (NUM_MOTORS == 1) ? '0 : IDX_W'(motor_index_i);

  assign out_ready  = !out_v_q || !out_stall_i;
  assign s2_ready   = !s2_v_q || out_ready;
  assign s1_ready   = !s1_v_q || s2_ready;
  assign accept     = in_valid_i && s1_ready;
  assign in_stall_o = !s1_ready;
  assign ld_mul     = s1_v_q && s2_ready;
  assign ld_out     = s2_v_q && out_ready;
  assign mem_we     = ld_mul && ramp.wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.accel_step    <= ACCEL_STEP_RST;
      cfg_q.brake_factor  <= BRAKE_FACTOR_RST;
      cfg_q.step_interval <= STEP_INTERVAL_RST;
      cfg_q.pwm_scale     <= PWM_SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_ACCEL_STEP:    cfg_q.accel_step    <= cfg_wdata_i[14:0];
        CFG_BRAKE_FACTOR:  cfg_q.brake_factor  <= cfg_wdata_i;
        CFG_STEP_INTERVAL: cfg_q.step_interval <= cfg_wdata_i;
        CFG_PWM_SCALE:     cfg_q.pwm_scale     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      fwd_v_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
      if (out_ready) begin
        out_v_q <= s2_v_q;
      end
      if (mem_we) begin
        fwd_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= requested_power_i;
      now_q <= now_ms_i;
      idx_q <= in_idx;
    end
    if (mem_we) begin
      fwd_idx_q  <= idx_q;
      fwd_data_q <= ramp.next;
    end
  end

  mprb_state_mem #(
    .NUM_MOTORS (NUM_MOTORS),
    .IDX_W      (IDX_W)
  ) u_state_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (in_idx),
    .rd_data_o (mem_rdata),
    .wr_en_i   (mem_we),
    .wr_addr_i (idx_q),
    .wr_data_i (ramp.next)
  );

  assign cur = (fwd_v_q && fwd_idx_q == idx_q) ? fwd_data_q : mem_rdata;

  mprb_ramp_calc u_ramp_calc (
    .cfg_i  (cfg_q),
    .cur_i  (cur),
    .req_i  (req_q),
    .now_i  (now_q),
    .ramp_o (ramp)
  );

  mprb_pwm_map u_pwm_map (
    .clk_i    (clk_i),
    .ld_mul_i (ld_mul),
    .ld_out_i (ld_out),
    .power_i  (ramp.result),
    .scale_i  (cfg_q.pwm_scale),
    .power_o  (ramp_power_int),
    .pwm_o    (pwm_int)
  );

  assign out_valid_o    = out_v_q;
  assign ramped_power_o = ramp_power_int;
  assign pwm_value_o    = pwm_int;

  // state memory is written only by an item leaving the update stage
  a_we_needs_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (s1_v_q && s2_ready))
    else $error("state write without an advancing item");

  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_v_q)
    else $error("accepted item lost before update stage");

  a_pwm_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ramped_power_o == 16'sd0) |-> (pwm_value_o == PWM_BASE_ZERO))
    else $error("zero power must map to the neutral PWM code");

  a_pwm_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ramped_power_o > 16'sd0) |-> (pwm_value_o >= 16'd25600))
    else $error("positive power below forward PWM base");

  a_pwm_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ramped_power_o < 16'sd0) |-> (pwm_value_o <= 16'd23040))
    else $error("negative power above reverse PWM base");

endmodule

@@ hw/rtl/mprb_state_mem.sv @@
module mprb_state_mem
  import mprb_pkg::*;
#(
  parameter int unsigned NUM_MOTORS = 2,
  parameter int unsigned IDX_W      = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output state_t           rd_data_o,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  state_t           wr_data_i
);

  state_t                mem_q [NUM_MOTORS];
  logic [NUM_MOTORS-1:0] valid_q;
  state_t                rdata_q;
  logic                  rvalid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvalid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvalid_q ? rdata_q : '0;

endmodule

@@ hw/rtl/mprb_ramp_calc.sv @@
module mprb_ramp_calc
  import mprb_pkg::*;
(
  input  cfg_t               cfg_i,
  input  state_t             cur_i,
  input  logic signed [15:0] req_i,
  input  logic        [31:0] now_i,
  output ramp_t              ramp_o
);

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v > 17'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -17'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  logic        [31:0] elapsed;
  logic               due;
  logic signed [16:0] cur_x;
  logic signed [16:0] diff;
  logic        [16:0] adiff;
  logic               close;
  logic        [15:0] mag;
  logic        [31:0] bprod;
  logic        [15:0] scaled;
  logic signed [15:0] braked;
  logic signed [16:0] up;
  logic signed [16:0] down;

  assign elapsed = now_i - cur_i.stamp;
  assign due     = elapsed >= {16'd0, cfg_i.step_interval};
  assign cur_x   = {cur_i.power[15], cur_i.power};
  assign diff    = {req_i[15], req_i} - cur_x;
  assign adiff   = diff[16] ? 17'(-diff) : 17'(diff);
  assign close   = adiff < {2'b00, cfg_i.accel_step};

  // brake: magnitude times factor, truncated toward zero; below ZERO_BRAKE_LIMIT it brakes to zero
  assign mag    = cur_i.power[15] ? 16'(~cur_i.power + 16'sd1) : 16'(cur_i.power);
  assign bprod  = mag * cfg_i.brake_factor;
  assign scaled = {1'b0, bprod[30:16]};
  always_comb begin
    if (mag < ZERO_BRAKE_LIMIT) begin
      braked = '0;
    end else if (cur_i.power[15]) begin
      braked = -$signed(scaled);
    end else begin
      braked = $signed(scaled);
    end
  end

  assign up   = cur_x + $signed({2'b00, cfg_i.accel_step});
  assign down = cur_x - $signed({2'b00, cfg_i.accel_step});

  always_comb begin
    ramp_o.wr         = 1'b0;
    ramp_o.next.power = cur_i.power;
    ramp_o.next.stamp = now_i;
    ramp_o.result     = cur_i.power;
    if (due) begin
      if (req_i == 16'sd0) begin
        ramp_o.wr         = 1'b1;
        ramp_o.next.power = braked;
        ramp_o.result     = braked;
      end else if (close) begin
        ramp_o.result = req_i;
      end else if (!diff[16] && diff != 17'sd0) begin
        ramp_o.wr         = 1'b1;
        ramp_o.next.power = sat16(up);
        ramp_o.result     = sat16(up);
      end else if (diff[16]) begin
        ramp_o.wr         = 1'b1;
        ramp_o.next.power = sat16(down);
        ramp_o.result     = sat16(down);
      end
    end
  end

endmodule

@@ hw/rtl/mprb_pwm_map.sv @@
module mprb_pwm_map
  import mprb_pkg::*;
(
  input  logic               clk_i,
  input  logic               ld_mul_i,
  input  logic               ld_out_i,
  input  logic signed [15:0] power_i,
  input  logic        [15:0] scale_i,
  output logic signed [15:0] power_o,
  output logic        [15:0] pwm_o
);

  logic signed [15:0] p_q;
  logic signed [32:0] prod;
  logic signed [18:0] frac;
  logic signed [18:0] sum;
  logic        [15:0] pwm_d;

  // multiply runs on the registered power, in a stage of its own
  assign prod = $signed({1'b0, scale_i}) * p_q;

  // floor(prod / 32768) is an arithmetic shift
  assign frac = {prod[32], prod[32:15]};
  assign sum  = (p_q[15] ? PWM_BASE_NEG : PWM_BASE_POS) + frac;

  always_comb begin
    if (p_q == 16'sd0) begin
      pwm_d = PWM_BASE_ZERO;
    end else if (sum < 19'sd0) begin
      pwm_d = '0;
    end else if (sum > 19'sd65535) begin
      pwm_d = 16'hffff;
    end else begin
      pwm_d = sum[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_mul_i) begin
      p_q <= power_i;
    end
    if (ld_out_i) begin
      power_o <= p_q;
      pwm_o   <= pwm_d;
    end
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
module tb;
  import mprb_pkg::*;

  // Fixed points of the power and PWM mapping
  localparam int ZERO_BRAKE_MAG = 3277;  // |power| below 0.1 in Q1.15 brakes to zero
  localparam int PWM_NEG_BASE   = 90;
  localparam int PWM_POS_BASE   = 100;
  localparam int PWM_ZERO_BASE  = 93;
  localparam int POWER_MAX      = 32767;
  localparam int POWER_MIN      = -32768;
  localparam int RANDOM_PHASES  = 5;
  localparam int PHASE_ITEMS    = 200;
  localparam int SETTLE_CYCLES  = 8;     // extra wait once no result is pending

  typedef struct packed {
    logic signed [15:0] power;
    logic        [15:0] pwm;
  } ramp_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic signed [15:0]    requested_power_i = '0;
  logic                  motor_index_i = 1'b0;
  logic [31:0]           now_ms_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic signed [15:0]    ramped_power_o;
  logic [15:0]           pwm_value_o;

  // Shadow copy of the block: registers and per-motor state
  int          accel_step;
  int          brake_factor;
  int          step_interval;
  int          pwm_scale;
  int          motor_power [2];
  logic [31:0] motor_stamp [2];

  ramp_out_t   pending_results [$];
  int          mismatch_count = 0;
  bit          no_idle = 1'b0;   // set for a stretch with no gaps on either side
  logic [31:0] clock_ms;         // running millisecond time for well-formed traffic

  always #2 clk_i = ~clk_i;

  motor_power_ramp_with_brake u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .requested_power_i(requested_power_i),
    .motor_index_i    (motor_index_i),
    .now_ms_i         (now_ms_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .ramped_power_o   (ramped_power_o),
    .pwm_value_o      (pwm_value_o)
  );

  // Works out the power and PWM command for one accepted item and updates
  // the shadow state the way the block must.
  function automatic ramp_out_t ramp_predict(input logic signed [15:0] req,
                                             input logic motor, input logic [31:0] now);
    int          cur;
    int          nxt;
    int          diff;
    int          adiff;
    longint      mag;
    longint      scaled;
    longint      prod;
    longint      pwm;
    logic [31:0] elapsed;
    ramp_out_t   r;
    cur = motor_power[motor];
    nxt = cur;
    elapsed = now - motor_stamp[motor];
    // Interval counted modulo 2^32; too soon means the present power holds
    if (elapsed >= step_interval) begin
      diff = req - cur;
      adiff = (diff < 0) ? -diff : diff;
      if (req == 0) begin
        // Brake: small power snaps to zero, else scale and truncate toward zero
        mag = (cur < 0) ? -cur : cur;
        if (mag < ZERO_BRAKE_MAG) begin
          nxt = 0;
        end else begin
          scaled = (mag * brake_factor) / 65536;
          nxt = int'((cur < 0) ? -scaled : scaled);
        end
        motor_power[motor] = nxt;
        motor_stamp[motor] = now;
      end else if (adiff < accel_step) begin
        // Close enough: pass the request through, store nothing
        nxt = req;
      end else if (req != cur) begin
        nxt = (req > cur) ? cur + accel_step : cur - accel_step;
        if (nxt > POWER_MAX) nxt = POWER_MAX;
        else if (nxt < POWER_MIN) nxt = POWER_MIN;
        motor_power[motor] = nxt;
        motor_stamp[motor] = now;
      end
    end
    r.power = nxt[15:0];
    if (nxt == 0) begin
      r.pwm = PWM_ZERO_BASE * 256;
    end else begin
      // Arithmetic shift floors the Q8.8 fraction for negative products too
      prod = longint'(pwm_scale) * nxt;
      pwm = ((nxt < 0) ? PWM_NEG_BASE : PWM_POS_BASE) * 256 + (prod >>> 15);
      if (pwm < 0) pwm = 0;
      else if (pwm > 65535) pwm = 65535;
      r.pwm = pwm[15:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 100) $display("%0t ns: %s", $time, msg);
  endtask

  // Result side: random stall, quiet during the no-idle stretch
  always @(negedge clk_i) begin
    out_stall_i <= !no_idle && ($urandom_range(99, 0) < 9);
  end

  // Both handshakes are looked at on the rising edge; the item taken is
  // predicted first, so a result is always matched against the oldest one.
  always @(posedge clk_i) begin : result_check
    ramp_out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        pending_results.push_back(ramp_predict(requested_power_i, motor_index_i, now_ms_i));
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result with no item waiting: power %0d pwm %0d",
                                    ramped_power_o, pwm_value_o));
        end else begin
          want = pending_results.pop_front();
          if (ramped_power_o !== want.power)
            report_mismatch($sformatf("ramped_power %0d, want %0d",
                                      ramped_power_o, want.power));
          if (pwm_value_o !== want.pwm)
            report_mismatch($sformatf("pwm_value %0d, want %0d (power %0d)",
                                      pwm_value_o, want.pwm, want.power));
        end
      end
    end
  end

  // Called on a falling edge; returns on the falling edge after the item is
  // taken, so the shadow state already reflects it.
  task automatic send_item(input logic signed [15:0] req, input logic motor,
                           input logic [31:0] now);
    while (!no_idle && $urandom_range(99, 0) < 9) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    requested_power_i = req;
    motor_index_i = motor;
    now_ms_i = now;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Lower valid and wait for every predicted item to come back
  task automatic wait_results_done();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Only while idle; the shadow registers follow at once
  task automatic write_reg(input cfg_reg_e idx, input int value);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = value[15:0];
    case (idx)
      CFG_ACCEL_STEP:    accel_step = value & 32'h7FFF;
      CFG_BRAKE_FACTOR:  brake_factor = value & 32'hFFFF;
      CFG_STEP_INTERVAL: step_interval = value & 32'hFFFF;
      CFG_PWM_SCALE:     pwm_scale = value & 32'hFFFF;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Reset register values: interval edges, pass-through, step both ways,
  // brake to zero and brake by the factor, time wrap, motor 1
  task automatic test_ramp_defaults();
    send_item(16'sd32767, 1'b0, 32'd9);          // one ms short of the interval
    send_item(16'sd32767, 1'b0, 32'd10);         // step up
    send_item(16'sd1000, 1'b0, 32'd20);          // within a step: passed through
    send_item(-16'sd32768, 1'b0, 32'd20);        // step down to zero
    send_item(-16'sd32768, 1'b1, 32'd20);
    send_item(-16'sd32768, 1'b1, 32'd30);
    send_item(16'sd0, 1'b1, 32'd40);             // just under 0.1: brakes to zero
    send_item(16'sd0, 1'b0, 32'd20);             // no time passed
    send_item(16'sd32767, 1'b0, 32'hFFFF_FFF0);
    send_item(16'sd32767, 1'b0, 32'h0000_0004);  // wrapped time
    send_item(16'sd32767, 1'b0, 32'h0000_000E);
    send_item(16'sd0, 1'b0, 32'h0000_0020);      // brake by the factor
    send_item(16'sd1, 1'b1, 32'd100);
    wait_results_done();
  endtask

  // Register extremes: full-scale step, brake factor ends, interval ends,
  // PWM saturation at both ends and a zero scale
  task automatic test_register_extremes();
    write_reg(CFG_ACCEL_STEP, 32767);
    write_reg(CFG_BRAKE_FACTOR, 65535);
    write_reg(CFG_STEP_INTERVAL, 0);
    write_reg(CFG_PWM_SCALE, 65535);
    send_item(16'sd32767, 1'b1, 32'd200);        // PWM saturates high
    send_item(16'sd0, 1'b1, 32'd200);
    send_item(-16'sd32768, 1'b1, 32'd200);
    send_item(-16'sd32768, 1'b1, 32'd200);       // PWM saturates low
    send_item(16'sd0, 1'b1, 32'd200);            // brake from the most negative power
    wait_results_done();
    write_reg(CFG_BRAKE_FACTOR, 0);
    write_reg(CFG_STEP_INTERVAL, 65535);
    write_reg(CFG_PWM_SCALE, 0);
    write_reg(CFG_ACCEL_STEP, 1);
    send_item(16'sd0, 1'b1, 32'd200);            // interval not reached
    send_item(16'sd0, 1'b1, 32'd200 + 32'd65535); // zero factor
    send_item(16'sd32767, 1'b0, 32'h0000_0020 + 32'd65535);
    send_item(-16'sd2, 1'b0, 32'h0000_0020 + 32'd65536);
    wait_results_done();
  endtask

  // Random register settings per phase, mostly well-formed traffic on a
  // running clock, with noise items carrying arbitrary time and power
  task automatic test_random_traffic();
    int          off;
    int          req;
    int          span;
    logic        motor;
    logic [31:0] now;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      no_idle = (phase == 2);
      write_reg(CFG_ACCEL_STEP, ($urandom_range(3, 0) == 0) ?
                ($urandom_range(1, 0) ? 32767 : 1) : $urandom_range(4000, 1));
      write_reg(CFG_BRAKE_FACTOR, ($urandom_range(3, 0) == 0) ?
                ($urandom_range(1, 0) ? 65535 : 0) : $urandom_range(65535, 0));
      write_reg(CFG_STEP_INTERVAL, ($urandom_range(4, 0) == 0) ?
                ($urandom_range(1, 0) ? 65535 : 0) : $urandom_range(40, 0));
      write_reg(CFG_PWM_SCALE, ($urandom_range(3, 0) == 0) ?
                ($urandom_range(1, 0) ? 65535 : 0) : $urandom_range(65535, 0));
      clock_ms = $urandom();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        motor = $urandom_range(1, 0);
        if ($urandom_range(99, 0) < 10) begin
          // noise: any power at any time
          req = $urandom_range(65535, 0) - 32768;
          now = $urandom();
        end else begin
          span = 2 * step_interval + 2;
          clock_ms = clock_ms + $urandom_range(span, 0);
          now = clock_ms;
          case ($urandom_range(3, 0))
            0: req = 0;
            1, 2: begin
              // near the present power, on both sides of one step
              off = $urandom_range(4 * accel_step, 0) - 2 * accel_step;
              req = motor_power[motor] + off;
              if (req > POWER_MAX) req = POWER_MAX;
              else if (req < POWER_MIN) req = POWER_MIN;
            end
            default: req = ($urandom_range(7, 0) == 0) ?
                           ($urandom_range(1, 0) ? POWER_MAX : POWER_MIN) :
                           $urandom_range(65535, 0) - 32768;
          endcase
        end
        send_item(req[15:0], motor, now);
      end
      wait_results_done();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    accel_step = ACCEL_STEP_RST;
    brake_factor = BRAKE_FACTOR_RST;
    step_interval = STEP_INTERVAL_RST;
    pwm_scale = PWM_SCALE_RST;
    for (int m = 0; m < 2; m++) begin
      motor_power[m] = 0;
      motor_stamp[m] = '0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_ramp_defaults();
    test_register_extremes();
    test_random_traffic();
    wait_results_done();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // A few hundred times the slowest expected run
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
